/* rtl/mcbps_pkg.sv */
// Shared constants, codes and decode helpers for the compare/branch pattern scanner.
// Used by mcbps_cand and mips_compare_branch_pattern_scanner; no dependencies.
package mcbps_pkg;

   localparam int RAM_WORDS_DEFAULT  = 524288;
   localparam int PAGE_BYTES_DEFAULT = 4096;
   localparam int LOOKAHEAD_DEFAULT  = 4;

   localparam int POS_W  = 20;
   localparam int IMM_W  = 15;
   localparam int WORD_W = 32;

   typedef logic [1:0] outcome_type;
   localparam outcome_type OUTCOME_NONE = 2'd0;
   localparam outcome_type OUTCOME_SLT  = 2'd1;
   localparam outcome_type OUTCOME_ADD  = 2'd2;

   typedef logic [0:0] csr_index_type;
   localparam csr_index_type CSR_IMM_MIN = 1'b0;
   localparam csr_index_type CSR_IMM_MAX = 1'b1;

   localparam logic [IMM_W-1:0] IMM_MIN_RESET = 15'd50;
   localparam logic [IMM_W-1:0] IMM_MAX_RESET = 15'd1000;

   localparam logic [5:0] OP_REGIMM = 6'h01;
   localparam logic [5:0] OP_ADDIU  = 6'h09;
   localparam logic [5:0] OP_SLTI   = 6'h0A;
   localparam logic [5:0] OP_SLTIU  = 6'h0B;
   localparam logic [5:0] OP_COP1   = 6'h11;
   localparam logic [4:0] RS_COP1_BC = 5'h08;

   localparam logic [15:0] IMM_SLT_PATCH = 16'h7FFF;
   localparam logic [15:0] IMM_ADD_PATCH = 16'h8001;

   function automatic logic [5:0] op_of(input logic [WORD_W-1:0] w);
      return w[31:26];
   endfunction

   function automatic logic [4:0] rs_of(input logic [WORD_W-1:0] w);
      return w[25:21];
   endfunction

   function automatic logic [4:0] rt_of(input logic [WORD_W-1:0] w);
      return w[20:16];
   endfunction

   function automatic logic regimm_branch(input logic [WORD_W-1:0] w);
      return (op_of(w) == OP_REGIMM) && (rt_of(w)[4:1] == 4'd0);
   endfunction

   function automatic logic branch_word(input logic [WORD_W-1:0] w);
      return (op_of(w)[5:2] == 4'd1) || regimm_branch(w) ||
             ((op_of(w) == OP_COP1) && (rs_of(w) == RS_COP1_BC));
   endfunction

endpackage

/* rtl/mcbps_cand.sv */
// Candidate check for one window entry: page placement, immediate range and pattern.
// Depends on mcbps_pkg.
module mcbps_cand #(
   parameter int RAM_WORDS  = mcbps_pkg::RAM_WORDS_DEFAULT,
   parameter int PAGE_BYTES = mcbps_pkg::PAGE_BYTES_DEFAULT
) (
   input  logic [mcbps_pkg::WORD_W-1:0] word,
   input  logic [mcbps_pkg::WORD_W-1:0] next_word,
   input  logic                         code_flag,
   input  logic [mcbps_pkg::POS_W-1:0]  pos,
   input  logic                         has_room,
   input  logic                         branch_ahead,
   input  logic [mcbps_pkg::IMM_W-1:0]  imm_min,
   input  logic [mcbps_pkg::IMM_W-1:0]  imm_max,
   output mcbps_pkg::outcome_type       kind
);
   import mcbps_pkg::*;

   localparam int PW      = PAGE_BYTES / 4;
   localparam int PW_BITS = $clog2(PW);

   logic [PW_BITS-1:0] page_off;
   logic [POS_W:0]     page_end;
   logic               place_ok;
   logic [15:0]        imm;
   logic [15:0]        mag;
   logic               slt_hit;
   logic               add_hit;

   assign page_off = pos[PW_BITS-1:0];
   assign page_end = {1'b0, pos[POS_W-1:PW_BITS], {PW_BITS{1'b0}}} + (POS_W+1)'(PW);
   assign place_ok = code_flag && has_room &&
                     (page_off <= PW_BITS'(PW - 4)) &&
                     (page_end <= (POS_W+1)'(RAM_WORDS));

   assign imm = word[15:0];
   assign mag = 16'd0 - imm;

   assign slt_hit = ((op_of(word) == OP_SLTI) || (op_of(word) == OP_SLTIU)) &&
                    !imm[15] && (imm[14:0] >= imm_min) && (imm[14:0] <= imm_max) &&
                    branch_ahead;

   assign add_hit = (op_of(word) == OP_ADDIU) && imm[15] &&
                    (mag >= {1'b0, imm_min}) && (mag <= {1'b0, imm_max}) &&
                    regimm_branch(next_word) && (rs_of(next_word) == rt_of(word));

   always_comb begin
      kind = OUTCOME_NONE;
      if (place_ok && slt_hit) begin
         kind = OUTCOME_SLT;
      end else if (place_ok && add_hit) begin
         kind = OUTCOME_ADD;
      end
   end

endmodule

/* rtl/mips_compare_branch_pattern_scanner.sv */
// Top level of the compare/branch pattern scanner: request register, word window,
// candidate checks and result register. Depends on mcbps_pkg and mcbps_cand.
//
//   channel | direction | handshake              | payload
//   req     | in        | req_valid / req_stall  | instr_word, in_code_page, last_word
//   rsp     | out       | rsp_valid / rsp_stall  | outcome, patch_address, patch_word,
//           |           |                        |   original_word
//   csr     | in        | csr_write_en           | csr_index, csr_write_data
//
// One request per cycle while req_stall is low; a taken request is held in the request
// register, which feeds the window's candidate checks, whose outcome goes to the result register.
// A match is reported when the word LOOKAHEAD (at least three) words later arrives,
// or on the last word; the last word always ends the scan and restarts the window.
// Synchronous reset empties the window, clears scan state and sets the limits to 50 and 1000.
// A stalled result holds its register; the request register still drains into it
// once it frees, so req_stall rises only while both registers are occupied.
module mips_compare_branch_pattern_scanner #(
   parameter int RAM_WORDS  = mcbps_pkg::RAM_WORDS_DEFAULT,
   parameter int PAGE_BYTES = mcbps_pkg::PAGE_BYTES_DEFAULT,
   parameter int LOOKAHEAD  = mcbps_pkg::LOOKAHEAD_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [mcbps_pkg::WORD_W-1:0]  req_instr_word,
   input  logic                          req_in_code_page,
   input  logic                          req_last_word,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output mcbps_pkg::outcome_type        rsp_outcome,
   output logic [mcbps_pkg::WORD_W-1:0]  rsp_patch_address,
   output logic [mcbps_pkg::WORD_W-1:0]  rsp_patch_word,
   output logic [mcbps_pkg::WORD_W-1:0]  rsp_original_word,
   input  logic                          csr_write_en,
   input  mcbps_pkg::csr_index_type      csr_index,
   input  logic [mcbps_pkg::IMM_W-1:0]   csr_write_data
);
   import mcbps_pkg::*;

   localparam int WIN    = (LOOKAHEAD > 3) ? LOOKAHEAD : 3;
   localparam int NENT   = WIN + 1;
   localparam int FILL_W = $clog2(WIN + 1);

   logic [IMM_W-1:0]   imm_min_ff, imm_max_ff;

   logic               s1_valid_ff, s1_valid_in;
   logic [WORD_W-1:0]  s1_word_ff;
   logic               s1_flag_ff;
   logic               s1_last_ff;

   logic [WORD_W-1:0]  win_word_ff [WIN];
   logic [WORD_W-1:0]  win_word_in [WIN];
   logic               win_flag_ff [WIN];
   logic               win_flag_in [WIN];
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [POS_W-1:0]   base_ff, base_in;
   logic               done_ff, done_in;

   logic               rsp_valid_ff, rsp_valid_in;
   outcome_type        rsp_outcome_ff, rsp_outcome_in;
   logic [WORD_W-1:0]  rsp_addr_ff, rsp_addr_in;
   logic [WORD_W-1:0]  rsp_patch_ff, rsp_patch_in;
   logic [WORD_W-1:0]  rsp_orig_ff, rsp_orig_in;

   logic               out_free, s1_fire, req_take;

   logic [WORD_W-1:0]  buf_word [NENT];
   logic               buf_flag [NENT];
   logic [POS_W-1:0]   buf_pos  [NENT];
   logic               buf_branch [NENT];
   outcome_type        ent_kind [NENT];
   logic               full;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_fire   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;
   assign s1_valid_in = req_take || (s1_valid_ff && !s1_fire);
   assign full = (fill_ff == FILL_W'(WIN));

   always_ff @(posedge clock) begin
      if (reset) begin
         imm_min_ff <= IMM_MIN_RESET;
         imm_max_ff <= IMM_MAX_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_IMM_MIN: imm_min_ff <= csr_write_data;
            CSR_IMM_MAX: imm_max_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_take) begin
         s1_word_ff <= req_instr_word;
         s1_flag_ff <= req_in_code_page;
         s1_last_ff <= req_last_word;
      end
   end

   for (genvar k = 0; k < NENT; k++) begin : g_ent
      logic       has_room;
      logic       ahead;
      logic [WORD_W-1:0] nxt;

      if (k < WIN) begin : g_old
         assign buf_word[k] = (FILL_W'(k) < fill_ff) ? win_word_ff[k] : s1_word_ff;
         assign buf_flag[k] = (FILL_W'(k) < fill_ff) ? win_flag_ff[k] : s1_flag_ff;
      end else begin : g_new
         assign buf_word[k] = s1_word_ff;
         assign buf_flag[k] = s1_flag_ff;
      end

      assign buf_pos[k]    = base_ff + POS_W'(k);
      assign buf_branch[k] = branch_word(buf_word[k]) && (FILL_W'(k) <= fill_ff);

      if (k + 3 <= WIN) begin : g_room
         assign has_room = (fill_ff >= FILL_W'(k + 3));
         assign nxt      = buf_word[k+1];
      end else begin : g_noroom
         assign has_room = 1'b0;
         assign nxt      = buf_word[k];
      end

      always_comb begin
         ahead = 1'b0;
         for (int j = k + 1; j < NENT; j++) begin
            if (j <= k + LOOKAHEAD) begin
               ahead = ahead | buf_branch[j];
            end
         end
      end

      mcbps_cand #(
         .RAM_WORDS  (RAM_WORDS),
         .PAGE_BYTES (PAGE_BYTES)
      ) u_cand (
         .word         (buf_word[k]),
         .next_word    (nxt),
         .code_flag    (buf_flag[k]),
         .pos          (buf_pos[k]),
         .has_room     (has_room),
         .branch_ahead (ahead),
         .imm_min      (imm_min_ff),
         .imm_max      (imm_max_ff),
         .kind         (ent_kind[k])
      );
   end

   always_comb begin
      logic        found;
      outcome_type sel_kind;
      logic [WORD_W-1:0] sel_word;
      logic [POS_W-1:0]  sel_pos;
      logic        report;

      found    = 1'b0;
      sel_kind = OUTCOME_NONE;
      sel_word = '0;
      sel_pos  = '0;
      for (int k = 0; k < NENT; k++) begin
         if (!found && (ent_kind[k] != OUTCOME_NONE)) begin
            found    = 1'b1;
            sel_kind = ent_kind[k];
            sel_word = buf_word[k];
            sel_pos  = buf_pos[k];
         end
      end

      win_word_in = win_word_ff;
      win_flag_in = win_flag_ff;
      fill_in     = fill_ff;
      base_in     = base_ff;
      done_in     = done_ff;
      report      = 1'b0;

      if (s1_fire) begin
         if (s1_last_ff) begin
            report  = !done_ff;
            fill_in = '0;
            base_in = '0;
            done_in = 1'b0;
         end else if (!done_ff) begin
            if (full && (ent_kind[0] != OUTCOME_NONE)) begin
               report  = 1'b1;
               done_in = 1'b1;
            end else if (full) begin
               for (int k = 0; k < WIN; k++) begin
                  win_word_in[k] = buf_word[k+1];
                  win_flag_in[k] = buf_flag[k+1];
               end
               base_in = base_ff + POS_W'(1);
            end else begin
               for (int k = 0; k < WIN; k++) begin
                  win_word_in[k] = buf_word[k];
                  win_flag_in[k] = buf_flag[k];
               end
               fill_in = fill_ff + FILL_W'(1);
            end
         end
      end

      rsp_valid_in   = out_free ? report : rsp_valid_ff;
      rsp_outcome_in = sel_kind;
      rsp_addr_in    = '0;
      rsp_patch_in   = '0;
      rsp_orig_in    = '0;
      if (sel_kind != OUTCOME_NONE) begin
         rsp_addr_in  = {1'b1, 9'd0, sel_pos, 2'b00};
         rsp_patch_in = {sel_word[31:16],
                         (sel_kind == OUTCOME_SLT) ? IMM_SLT_PATCH : IMM_ADD_PATCH};
         rsp_orig_in  = sel_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         base_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         base_ff <= base_in;
         done_ff <= done_in;
      end
      win_word_ff <= win_word_in;
      win_flag_ff <= win_flag_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (out_free) begin
         rsp_outcome_ff <= rsp_outcome_in;
         rsp_addr_ff    <= rsp_addr_in;
         rsp_patch_ff   <= rsp_patch_in;
         rsp_orig_ff    <= rsp_orig_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_outcome       = rsp_outcome_ff;
   assign rsp_patch_address = rsp_addr_ff;
   assign rsp_patch_word    = rsp_patch_ff;
   assign rsp_original_word = rsp_orig_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(WIN))
      else $error("window fill beyond window size");

   a_done_quiet: assert property (@(posedge clock) disable iff (reset)
      s1_fire && done_ff |=> !rsp_valid_ff)
      else $error("result produced after scan already matched");

   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_outcome_ff == OUTCOME_NONE) |->
         (rsp_addr_ff == '0) && (rsp_patch_ff == '0) && (rsp_orig_ff == '0))
      else $error("empty outcome carries nonzero payload");

   a_match_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_outcome_ff != OUTCOME_NONE) |->
         rsp_addr_ff[31] && (rsp_orig_ff[31:16] == rsp_patch_ff[31:16]))
      else $error("match result payload inconsistent");

endmodule
